@@ hw/rtl/wma_pkg.sv @@
// Shared types, register codes and gain table for the windowed moving average.
`timescale 1ns / 1ps
`default_nettype none

package wma_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL  = 2'd1;

    // Gain selection
    localparam int unsigned LVL_W   = 4;
    localparam logic [LVL_W-1:0] LVL_MAX = 4'd10;
    localparam int unsigned GAIN_W  = 13;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned COUNT_W = 32;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic rd_ring;
        logic upd_sum;
        logic div_start;
        logic set_mean;
        logic mul;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_busy;
    } t_sts;

    // Q8 gain for each level
    function automatic logic [GAIN_W-1:0] gain_q8(input logic [LVL_W-1:0] lvl);
        logic [GAIN_W-1:0] g;
        case (lvl)
            4'd0:    g = 13'd256;
            4'd1:    g = 13'd320;
            4'd2:    g = 13'd422;
            4'd3:    g = 13'd512;
            4'd4:    g = 13'd1024;
            4'd5:    g = 13'd1536;
            4'd6:    g = 13'd2048;
            4'd7:    g = 13'd2560;
            4'd8:    g = 13'd3072;
            4'd9:    g = 13'd3584;
            default: g = 13'd4096;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/windowed_moving_average_top.sv @@
// Top level of the windowed moving average with selectable output gain.
// Items are taken one at a time: the input is ready only while the controller is idle.
// Each item passes through the bit-serial divider, which produces one quotient bit per cycle.
// A result waits in the output register while the next item is already taken in.
// Reset (synchronous, active low) restores window MAX_WINDOW and level 0, clears sum and counts.
// The ring memory is not swept: entries beyond the fill count read as zero.
`timescale 1ns / 1ps
`default_nettype none

module windowed_moving_average_top
    import wma_pkg::*;
#(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [((($clog2(MAX_WINDOW+1)) > LVL_W) ?
                        ($clog2(MAX_WINDOW+1)) : LVL_W)-1:0] i_cfg_data,
    // input item stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata: mean_value, scaled_mean, sample_count, zero pad
    output logic [((2*SAMPLE_BITS+2*FRAC_W+4+COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned MEAN_W    = SAMPLE_BITS + FRAC_W;
    localparam int unsigned SCALED_W  = MEAN_W + 4;
    localparam int unsigned OUT_W     = MEAN_W + SCALED_W + COUNT_W;
    localparam int unsigned OUT_TD_W  = ((OUT_W + 7) / 8) * 8;

    t_cmd cmd;
    t_sts sts;

    logic [MEAN_W-1:0]   mean;
    logic [SCALED_W-1:0] scaled;
    logic [COUNT_W-1:0]  count;

    // Controller walks each item through read, sum update, divide, gain and load.
    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wma_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_mean      (mean),
        .o_scaled    (scaled),
        .o_count     (count)
    );

    // Pack result fields, first field lowest, zero fill to whole bytes.
    assign m_axis_tdata = OUT_TD_W'({count, scaled, mean});

endmodule

`default_nettype wire

@@ hw/rtl/wma_div.sv @@
// Bit-serial restoring divider for unsigned dividend and divisor.
`timescale 1ns / 1ps
`default_nettype none

module wma_div #(
    parameter int unsigned DIVD_W = 30,
    parameter int unsigned DVSR_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [DVSR_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quotient
);

    localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   diff;

    assign rem_sh = {r_rem, r_quo[DIVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DVSR_W]) begin
                r_rem <= diff[DVSR_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DVSR_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/wma_ctrl.sv @@
// Sequencing state machine of the windowed moving average.
`timescale 1ns / 1ps
`default_nettype none

module wma_ctrl
    import wma_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_SUM    = 8'b0000_0100,
        S_DSTART = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_MEAN   = 8'b0010_0000,
        S_MUL    = 8'b0100_0000,
        S_LOAD   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_ring = 1'b1;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.upd_sum = 1'b1;
                n_state       = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.set_mean = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/wma_dp.sv @@
// Datapath: sample ring, running sum, counters, divider, gain and output register.
`timescale 1ns / 1ps
`default_nettype none

module wma_dp
    import wma_pkg::*;
#(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  wire logic [((($clog2(MAX_WINDOW+1)) > LVL_W) ?
                        ($clog2(MAX_WINDOW+1)) : LVL_W)-1:0] i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  wire t_cmd                          i_cmd,
    output t_sts                               o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [SAMPLE_BITS+FRAC_W-1:0]      o_mean,
    output logic [SAMPLE_BITS+FRAC_W+3:0]      o_scaled,
    output logic [COUNT_W-1:0]                 o_count
);

    localparam int unsigned WIN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int unsigned IDX_W    = $clog2(MAX_WINDOW);
    localparam int unsigned SUM_W    = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int unsigned DIVD_W   = SUM_W + FRAC_W;
    localparam int unsigned MEAN_W   = SAMPLE_BITS + FRAC_W;
    localparam int unsigned SCALED_W = MEAN_W + 4;
    localparam int unsigned PROD_W   = MEAN_W + GAIN_W + 1;

    // configuration
    logic [WIN_BITS-1:0] r_win;
    logic [LVL_W-1:0]    r_lvl;
    logic [WIN_BITS-1:0] win_raw;
    logic [LVL_W-1:0]    lvl_raw;

    // stored state
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic signed [SUM_W-1:0] r_sum;
    logic [WIN_BITS-1:0]     r_fill;
    logic [IDX_W-1:0]        r_widx;
    logic [COUNT_W-1:0]      r_total;

    // per-item working registers
    logic [SAMPLE_BITS-1:0]    r_sample;
    logic [SAMPLE_BITS-1:0]    r_old;
    logic                      r_neg;
    logic signed [MEAN_W-1:0]  r_mean;
    logic signed [PROD_W-1:0]  r_prod;

    // output register
    logic                      r_out_valid;
    logic [MEAN_W-1:0]         r_out_mean;
    logic [SCALED_W-1:0]       r_out_scaled;
    logic [COUNT_W-1:0]        r_out_count;

    logic [SAMPLE_BITS-1:0]    old_eff;
    logic signed [SUM_W-1:0]   n_sum;
    logic [WIN_BITS-1:0]       idx_inc;
    logic [SUM_W-1:0]          sum_mag;
    logic                      div_done;
    logic [DIVD_W-1:0]         quotient;
    logic [MEAN_W-1:0]         q_mean;

    assign win_raw = i_cfg_data[WIN_BITS-1:0];
    assign lvl_raw = i_cfg_data[LVL_W-1:0];

    // An entry past the fill count was never written since the last clear: read it as zero.
    assign old_eff = (r_fill == r_win) ? r_old : '0;
    assign n_sum   = r_sum
                   - $signed({{(SUM_W-SAMPLE_BITS){old_eff[SAMPLE_BITS-1]}}, old_eff})
                   + $signed({{(SUM_W-SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample});
    assign idx_inc = WIN_BITS'(r_widx) + 1'b1;
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign q_mean  = quotient[MEAN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_BITS'(MAX_WINDOW);
            r_lvl       <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_widx      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == REG_WINDOW)) begin
                if (win_raw == '0) begin
                    r_win <= WIN_BITS'(1);
                end else if (win_raw > WIN_BITS'(MAX_WINDOW)) begin
                    r_win <= WIN_BITS'(MAX_WINDOW);
                end else begin
                    r_win <= win_raw;
                end
                r_sum   <= '0;
                r_fill  <= '0;
                r_widx  <= '0;
                r_total <= '0;
            end else if (i_cfg_we && (i_cfg_addr == REG_LEVEL)) begin
                r_lvl <= (lvl_raw > LVL_MAX) ? LVL_MAX : lvl_raw;
            end else if (i_cmd.upd_sum) begin
                r_sum   <= n_sum;
                r_widx  <= (idx_inc >= r_win) ? '0 : IDX_W'(idx_inc);
                r_total <= r_total + 1'b1;
                if (r_fill < r_win) begin
                    r_fill <= r_fill + 1'b1;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ring memory: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ring) begin
            r_old <= ring[r_widx];
        end
        if (i_cmd.upd_sum) begin
            ring[r_widx] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.set_mean) begin
            r_mean <= r_neg ? $signed(-q_mean) : $signed(q_mean);
        end
        if (i_cmd.mul) begin
            r_prod <= r_mean * $signed({1'b0, gain_q8(r_lvl)});
        end
        if (i_cmd.load_out) begin
            r_out_mean   <= r_mean;
            r_out_scaled <= r_prod[SCALED_W+FRAC_W-1:FRAC_W];
            r_out_count  <= r_total;
        end
    end

    wma_div #(
        .DIVD_W (DIVD_W),
        .DVSR_W (WIN_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({sum_mag, {FRAC_W{1'b0}}}),
        .i_divisor  (r_fill),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_mean      = r_out_mean;
    assign o_scaled    = r_out_scaled;
    assign o_count     = r_out_count;

endmodule

`default_nettype wire

@@ hw/rtl/wma_chk.sv @@
// Port-level checker for the windowed moving average, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wma_chk #(
    parameter int unsigned OUT_W = 88
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // one item at a time: input closes after an item is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input open right after accepting an item");

    // a new result only appears out of the busy phase of an item
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without an item in work");

endmodule

bind windowed_moving_average_top wma_chk #(
    .OUT_W (OUT_TD_W)
) u_wma_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
